// ===== rtl/core/bps_pkg.sv =====
// shared types, codes and helpers for the bps patch applier
package bps_pkg;

  localparam int unsigned CFG_W         = 24;
  localparam int unsigned POS_W         = 26;
  localparam int unsigned SRC_DEPTH_DEF = 65536;
  localparam int unsigned TGT_DEPTH_DEF = 65536;

  localparam logic [31:0] CRC_POLY      = 32'hEDB88320;
  localparam logic [23:0] MIN_PATCH_LEN = 24'd19;
  localparam logic [24:0] TRAILER_LEN   = 25'd12;

  localparam logic [1:0] CFG_PATCH_LEN  = 2'd0;
  localparam logic [1:0] CFG_SRC_LEN    = 2'd1;
  localparam logic [1:0] CFG_TGT_CAP    = 2'd2;

  typedef enum logic [1:0] {
    CMD_LOAD    = 2'd0,
    CMD_PATCH   = 2'd1,
    CMD_READ    = 2'd2,
    CMD_RESTART = 2'd3
  } cmd_e;

  typedef enum logic [3:0] {
    ST_IDLE      = 4'd0,
    ST_RUNNING   = 4'd1,
    ST_OK        = 4'd2,
    ST_SMALL     = 4'd3,
    ST_HEADER    = 4'd4,
    ST_SRC_SMALL = 4'd5,
    ST_TGT_SMALL = 4'd6,
    ST_CRC_SRC   = 4'd7,
    ST_CRC_TGT   = 4'd8,
    ST_CRC_PATCH = 4'd9,
    ST_RANGE     = 4'd10
  } status_e;

  typedef enum logic [3:0] {
    PH_HEADER, PH_SRC_SIZE, PH_TGT_SIZE, PH_MARKUP_SIZE, PH_MARKUP,
    PH_CMD, PH_OFFSET, PH_TREAD, PH_TRAILER, PH_DONE
  } phase_e;

  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_RUN_RD, S_RUN_WR, S_FIN_RD, S_FIN_CRC, S_RESP
  } state_e;

  typedef struct packed {
    logic load_item;
    logic exec;
    logic run_check;
    logic run_write;
    logic fin_check;
    logic fin_acc;
    logic resp_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_patch;
    logic run_start;
    logic fin_start;
    logic run_done;
    logic run_fault;
    logic fin_last;
    logic out_free;
  } dp_status_t;

  function automatic logic [31:0] crc32_byte(logic [31:0] crc, logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [7:0] magic_byte(logic [1:0] idx);
    logic [7:0] m;
    case (idx)
      2'd0:    m = 8'h42;
      2'd1:    m = 8'h50;
      2'd2:    m = 8'h53;
      default: m = 8'h31;
    endcase
    return m;
  endfunction

endpackage

// ===== rtl/core/bps_patch_applier_core.sv =====
// top level of the bps patch applier
//
// Input stream: tuser carries the command (load source byte, next patch
// byte, read target byte, restart job); tdata carries address and byte.
// Every accepted word gives exactly one result word on the output stream:
// job status, the target byte read (zero otherwise) and the declared
// target size.
// Configuration (patch length, source length, target capacity) is written
// through cfg_we_i / cfg_index_i / cfg_data_i while no word is in flight.
// A load, read or restart word passes through the execute and response
// states; its result word is loaded into the output register in the latter.
// A patch byte passes through the execute state; a source read or copy
// command then emits each target byte with one store read and one store
// write each, and ends with an end-of-run check; the last trailer byte
// adds a source checksum walk over the source store read port, one read
// and one checksum step per source byte plus a final check.
// Reset clears all job state and configuration; the stores hold no defined
// contents until written. A stalled result sits in the output register;
// the next word is taken and worked on, and its result waits until the
// register frees, with the input held off meanwhile.
module bps_patch_applier_core #(
  parameter int unsigned SOURCE_DEPTH = bps_pkg::SRC_DEPTH_DEF,
  parameter int unsigned TARGET_DEPTH = bps_pkg::TGT_DEPTH_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [1:0]                cfg_index_i,
  input  logic [bps_pkg::CFG_W-1:0] cfg_data_i,
  input  logic                      s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  input  logic [23:0]               s_axis_tdata_i,  // address[15:0], data_byte[23:16]
  input  logic [1:0]                s_axis_tuser_i,  // cmd[1:0]
  output logic                      m_axis_tvalid_o,
  input  logic                      m_axis_tready_i,
  output logic [31:0]               m_axis_tdata_o   // status[3:0], read_data[11:4],
                                                     // target_size[28:12], zero[31:29]
);

  bps_pkg::ctrl_cmd_t  cmd;
  bps_pkg::dp_status_t dp_status;
  logic [3:0]  out_status;
  logic [7:0]  out_read_data;
  logic [16:0] out_target_size;

  bps_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .status_i   (dp_status),
    .cmd_o      (cmd)
  );

  bps_datapath #(
    .SOURCE_DEPTH (SOURCE_DEPTH),
    .TARGET_DEPTH (TARGET_DEPTH)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .in_cmd_i          (s_axis_tuser_i),
    .in_addr_i         (s_axis_tdata_i[15:0]),
    .in_data_i         (s_axis_tdata_i[23:16]),
    .cmd_i             (cmd),
    .status_o          (dp_status),
    .out_valid_o       (m_axis_tvalid_o),
    .out_ready_i       (m_axis_tready_i),
    .out_status_o      (out_status),
    .out_read_data_o   (out_read_data),
    .out_target_size_o (out_target_size)
  );

  assign m_axis_tdata_o = {3'b000, out_target_size, out_read_data, out_status};

endmodule

// ===== rtl/core/bps_ram.sv =====
// generic simple dual-port ram with registered read
module bps_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/bps_datapath.sv =====
// job registers, parser, crc units, stores and result register
module bps_datapath #(
  parameter int unsigned SOURCE_DEPTH = bps_pkg::SRC_DEPTH_DEF,
  parameter int unsigned TARGET_DEPTH = bps_pkg::TGT_DEPTH_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [1:0]               cfg_index_i,
  input  logic [bps_pkg::CFG_W-1:0] cfg_data_i,
  input  logic [1:0]               in_cmd_i,
  input  logic [15:0]              in_addr_i,
  input  logic [7:0]               in_data_i,
  input  bps_pkg::ctrl_cmd_t       cmd_i,
  output bps_pkg::dp_status_t      status_o,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [3:0]               out_status_o,
  output logic [7:0]               out_read_data_o,
  output logic [16:0]              out_target_size_o
);

  localparam int unsigned PW  = bps_pkg::POS_W;
  localparam int unsigned SAW = $clog2(SOURCE_DEPTH);
  localparam int unsigned TAW = $clog2(TARGET_DEPTH);
  localparam logic [PW-1:0] SRC_DEPTH_P = PW'(SOURCE_DEPTH);
  localparam logic [PW-1:0] TGT_DEPTH_P = PW'(TARGET_DEPTH);

  // configuration
  logic [23:0] pl_q, pl_d;
  logic [16:0] sl_q, sl_d, tc_q, tc_d;

  // job state
  bps_pkg::status_e status_q, status_d;
  bps_pkg::phase_e  phase_q, phase_d;
  logic [31:0] pcrc_q, pcrc_d, tcrc_q, tcrc_d, fcrc_q, fcrc_d;
  logic [23:0] bc_q, bc_d, mr_q, mr_d;
  logic [63:0] vv_q, vv_d;
  logic [6:0]  vs_q, vs_d;
  logic [1:0]  mode_q, mode_d;
  logic [16:0] rem_q, rem_d, op_q, op_d, dts_q, dts_d;
  logic [PW-1:0] scp_q, scp_d, tcp_q, tcp_d, fi_q, fi_d;
  logic [31:0] chk_q [3];
  logic [31:0] chk_d [3];
  logic [3:0]  tcnt_q, tcnt_d;

  // item and result
  bps_pkg::cmd_e icmd_q;
  logic [15:0] iaddr_q;
  logic [7:0]  idata_q;
  logic        rd_ok_q, rd_ok_d;
  logic        ov_q, ov_d;
  logic [3:0]  ostat_q;
  logic [7:0]  ord_q;
  logic [16:0] ots_q;

  // store ports
  logic          src_we, src_re, tgt_we, tgt_re;
  logic [PW-1:0] src_raddr_w, tgt_raddr_w;
  logic [7:0]    src_rdata, tgt_rdata, tw_byte;
  logic [PW-1:0] iaddr_w, op_w;

  // helpers
  logic [PW-1:0] src_eff, cap_eff, rpos, rlimit, opos, odepth, newpos;
  logic [63:0]   term, vsum, len, mag;
  logic [6:0]    vs_next;
  logic          vdone, obad;
  logic [23:0]   bc_inc;
  logic [31:0]   room;
  bps_pkg::phase_e ent_exec, ent_run;
  logic          run_done, run_fault, fin_last;
  logic          run_start, fin_start, step_ok;

  assign iaddr_w = PW'(iaddr_q);
  assign op_w    = PW'(op_q);
  assign src_eff = (PW'(sl_q) < SRC_DEPTH_P) ? PW'(sl_q) : SRC_DEPTH_P;
  assign cap_eff = (PW'(tc_q) < TGT_DEPTH_P) ? PW'(tc_q) : TGT_DEPTH_P;

  // varint: continuation adds 0x80 << shift, folded into one add
  assign vdone   = idata_q[7];
  assign term    = vs_q[6] ? 64'd0 : ({56'd0, ~idata_q[7], idata_q[6:0]} << vs_q[5:0]);
  assign vsum    = vv_q + term;
  assign vs_next = vs_q[6] ? 7'd70 : vs_q + 7'd7;

  assign bc_inc   = (bc_q != 24'hFFFFFF) ? bc_q + 24'd1 : bc_q;
  assign ent_exec = (({1'b0, bc_inc} + bps_pkg::TRAILER_LEN) < {1'b0, pl_q}) ?
                    bps_pkg::PH_CMD : bps_pkg::PH_TRAILER;
  assign ent_run  = (({1'b0, bc_q} + bps_pkg::TRAILER_LEN) < {1'b0, pl_q}) ?
                    bps_pkg::PH_CMD : bps_pkg::PH_TRAILER;

  assign room = 32'(cap_eff) - 32'(op_q);
  assign len  = {2'b00, vsum[63:2]} + 64'd1;

  // copy offset
  assign opos   = (mode_q == 2'd2) ? scp_q : tcp_q;
  assign odepth = (mode_q == 2'd2) ? SRC_DEPTH_P : TGT_DEPTH_P;
  assign mag    = {1'b0, vsum[63:1]};
  assign obad   = vsum[0] ? (mag > 64'(opos)) : (mag >= 64'(odepth));
  assign newpos = vsum[0] ? (opos - mag[PW-1:0]) : (opos + mag[PW-1:0]);

  // run engine position and limit
  always_comb begin
    case (mode_q)
      2'd0:    rpos = op_w;
      2'd3:    rpos = tcp_q;
      default: rpos = scp_q;
    endcase
  end
  assign rlimit    = (mode_q != 2'd3) ? src_eff : op_w;
  assign run_done  = (rem_q == 17'd0);
  assign run_fault = !run_done && (rpos >= rlimit);
  assign fin_last  = (fi_q == src_eff);

  always_comb begin
    pl_d = pl_q; sl_d = sl_q; tc_d = tc_q;
    status_d = status_q; phase_d = phase_q;
    pcrc_d = pcrc_q; tcrc_d = tcrc_q; fcrc_d = fcrc_q;
    bc_d = bc_q; mr_d = mr_q; vv_d = vv_q; vs_d = vs_q;
    mode_d = mode_q; rem_d = rem_q; op_d = op_q; dts_d = dts_q;
    scp_d = scp_q; tcp_d = tcp_q; fi_d = fi_q; tcnt_d = tcnt_q;
    for (int i = 0; i < 3; i++) chk_d[i] = chk_q[i];
    rd_ok_d = rd_ok_q;
    run_start = 1'b0;
    fin_start = 1'b0;
    step_ok   = 1'b0;
    tgt_we    = 1'b0;
    tw_byte   = idata_q;

    if (cfg_we_i) begin
      unique case (cfg_index_i)
        bps_pkg::CFG_PATCH_LEN: pl_d = cfg_data_i;
        bps_pkg::CFG_SRC_LEN:   sl_d = cfg_data_i[16:0];
        bps_pkg::CFG_TGT_CAP:   tc_d = cfg_data_i[16:0];
        default: ;
      endcase
    end

    if (cmd_i.exec) begin
      unique case (icmd_q)
        bps_pkg::CMD_LOAD: ;
        bps_pkg::CMD_READ: begin
          rd_ok_d = (iaddr_w < op_w) && (iaddr_w < TGT_DEPTH_P);
        end
        bps_pkg::CMD_RESTART: begin
          status_d = bps_pkg::ST_IDLE; phase_d = bps_pkg::PH_HEADER;
          pcrc_d = '1; tcrc_d = '1; bc_d = '0; mr_d = '0; vv_d = '0; vs_d = '0;
          mode_d = '0; rem_d = '0; op_d = '0; dts_d = '0;
          scp_d = '0; tcp_d = '0; tcnt_d = '0;
          for (int i = 0; i < 3; i++) chk_d[i] = '0;
        end
        default: begin
          if (status_q == bps_pkg::ST_IDLE) begin
            if (pl_q < bps_pkg::MIN_PATCH_LEN) begin
              status_d = bps_pkg::ST_SMALL;
            end else begin
              status_d = bps_pkg::ST_RUNNING;
              step_ok  = 1'b1;
            end
          end else if (status_q == bps_pkg::ST_RUNNING) begin
            step_ok = 1'b1;
          end
          if (step_ok) begin
            bc_d = bc_inc;
            // the patch checksum itself stays out of the patch crc
            if (!(phase_q == bps_pkg::PH_TRAILER && tcnt_q >= 4'd8)) begin
              pcrc_d = bps_pkg::crc32_byte(pcrc_q, idata_q);
            end
            case (phase_q)
              bps_pkg::PH_HEADER: begin
                if (idata_q != bps_pkg::magic_byte(bc_q[1:0])) begin
                  status_d = bps_pkg::ST_HEADER;
                end else if (bc_inc >= 24'd4) begin
                  phase_d = bps_pkg::PH_SRC_SIZE; vv_d = '0; vs_d = '0;
                end
              end
              bps_pkg::PH_SRC_SIZE: begin
                if (vdone) begin
                  if (vsum > 64'(src_eff)) begin
                    status_d = bps_pkg::ST_SRC_SMALL;
                  end else begin
                    phase_d = bps_pkg::PH_TGT_SIZE; vv_d = '0; vs_d = '0;
                  end
                end else begin
                  vv_d = vsum; vs_d = vs_next;
                end
              end
              bps_pkg::PH_TGT_SIZE: begin
                if (vdone) begin
                  dts_d = (vsum > 64'h1FFFF) ? 17'h1FFFF : vsum[16:0];
                  if (vsum > 64'(cap_eff)) begin
                    status_d = bps_pkg::ST_TGT_SMALL;
                  end else begin
                    phase_d = bps_pkg::PH_MARKUP_SIZE; vv_d = '0; vs_d = '0;
                  end
                end else begin
                  vv_d = vsum; vs_d = vs_next;
                end
              end
              bps_pkg::PH_MARKUP_SIZE: begin
                if (vdone) begin
                  mr_d = (vsum > 64'hFFFFFF) ? 24'hFFFFFF : vsum[23:0];
                  vv_d = '0; vs_d = '0;
                  phase_d = (vsum == 64'd0) ? ent_exec : bps_pkg::PH_MARKUP;
                end else begin
                  vv_d = vsum; vs_d = vs_next;
                end
              end
              bps_pkg::PH_MARKUP: begin
                mr_d = mr_q - 24'd1;
                if (mr_q == 24'd1) begin
                  phase_d = ent_exec; vv_d = '0; vs_d = '0;
                end
              end
              bps_pkg::PH_CMD: begin
                if (vdone) begin
                  mode_d = vsum[1:0];
                  if (len > {32'd0, room}) begin
                    status_d = bps_pkg::ST_RANGE;
                  end else begin
                    rem_d = len[16:0]; vv_d = '0; vs_d = '0;
                    case (vsum[1:0])
                      2'd0:    run_start = 1'b1;
                      2'd1:    phase_d = bps_pkg::PH_TREAD;
                      default: phase_d = bps_pkg::PH_OFFSET;
                    endcase
                  end
                end else begin
                  vv_d = vsum; vs_d = vs_next;
                end
              end
              bps_pkg::PH_OFFSET: begin
                if (vdone) begin
                  if (obad) begin
                    status_d = bps_pkg::ST_RANGE;
                  end else begin
                    if (mode_q == 2'd2) scp_d = newpos;
                    else tcp_d = newpos;
                    run_start = 1'b1;
                  end
                end else begin
                  vv_d = vsum; vs_d = vs_next;
                end
              end
              bps_pkg::PH_TREAD: begin
                tgt_we = 1'b1;
                tcrc_d = bps_pkg::crc32_byte(tcrc_q, idata_q);
                op_d   = op_q + 17'd1;
                rem_d  = rem_q - 17'd1;
                if (rem_q == 17'd1) begin
                  phase_d = ent_exec; vv_d = '0; vs_d = '0;
                end
              end
              bps_pkg::PH_TRAILER: begin
                chk_d[tcnt_q[3:2]] = chk_q[tcnt_q[3:2]] |
                                     (32'(idata_q) << {tcnt_q[1:0], 3'b000});
                tcnt_d = tcnt_q + 4'd1;
                if (tcnt_q == 4'd11) begin
                  fin_start = 1'b1; fi_d = '0; fcrc_d = '1;
                end
              end
              default: ;
            endcase
          end
        end
      endcase
    end

    if (cmd_i.run_check) begin
      if (run_done) begin
        phase_d = ent_run; vv_d = '0; vs_d = '0;
      end else if (run_fault) begin
        status_d = bps_pkg::ST_RANGE;
      end
    end

    if (cmd_i.run_write) begin
      tgt_we  = 1'b1;
      tw_byte = (mode_q == 2'd3) ? tgt_rdata : src_rdata;
      tcrc_d  = bps_pkg::crc32_byte(tcrc_q, tw_byte);
      op_d    = op_q + 17'd1;
      rem_d   = rem_q - 17'd1;
      if (mode_q == 2'd2) scp_d = scp_q + PW'(1);
      if (mode_q == 2'd3) tcp_d = tcp_q + PW'(1);
    end

    if (cmd_i.fin_check) begin
      if (fin_last) begin
        phase_d = bps_pkg::PH_DONE;
        if (~fcrc_q != chk_q[0])      status_d = bps_pkg::ST_CRC_SRC;
        else if (~tcrc_q != chk_q[1]) status_d = bps_pkg::ST_CRC_TGT;
        else if (~pcrc_q != chk_q[2]) status_d = bps_pkg::ST_CRC_PATCH;
        else                          status_d = bps_pkg::ST_OK;
      end else begin
        fi_d = fi_q + PW'(1);
      end
    end

    if (cmd_i.fin_acc) begin
      fcrc_d = bps_pkg::crc32_byte(fcrc_q, src_rdata);
    end
  end

  // store port selection
  assign src_we = cmd_i.exec && (icmd_q == bps_pkg::CMD_LOAD) && (iaddr_w < SRC_DEPTH_P);
  assign src_re = (cmd_i.run_check && !run_done && !run_fault && (mode_q != 2'd3)) ||
                  (cmd_i.fin_check && !fin_last);
  assign src_raddr_w = cmd_i.fin_check ? fi_q : rpos;
  assign tgt_re = (cmd_i.exec && (icmd_q == bps_pkg::CMD_READ)) ||
                  (cmd_i.run_check && !run_done && !run_fault && (mode_q == 2'd3));
  assign tgt_raddr_w = cmd_i.exec ? iaddr_w : tcp_q;

  bps_ram #(.WIDTH(8), .DEPTH(SOURCE_DEPTH)) u_src_ram (
    .clk_i   (clk_i),
    .we_i    (src_we),
    .waddr_i (iaddr_w[SAW-1:0]),
    .wdata_i (idata_q),
    .re_i    (src_re),
    .raddr_i (src_raddr_w[SAW-1:0]),
    .rdata_o (src_rdata)
  );

  bps_ram #(.WIDTH(8), .DEPTH(TARGET_DEPTH)) u_tgt_ram (
    .clk_i   (clk_i),
    .we_i    (tgt_we),
    .waddr_i (op_w[TAW-1:0]),
    .wdata_i (tw_byte),
    .re_i    (tgt_re),
    .raddr_i (tgt_raddr_w[TAW-1:0]),
    .rdata_o (tgt_rdata)
  );

  assign ov_d = cmd_i.resp_load ? 1'b1 : (ov_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pl_q <= '0; sl_q <= '0; tc_q <= '0;
      status_q <= bps_pkg::ST_IDLE; phase_q <= bps_pkg::PH_HEADER;
      pcrc_q <= '1; tcrc_q <= '1; fcrc_q <= '1;
      bc_q <= '0; mr_q <= '0; vv_q <= '0; vs_q <= '0;
      mode_q <= '0; rem_q <= '0; op_q <= '0; dts_q <= '0;
      scp_q <= '0; tcp_q <= '0; fi_q <= '0; tcnt_q <= '0;
      for (int i = 0; i < 3; i++) chk_q[i] <= '0;
      rd_ok_q <= 1'b0;
      ov_q <= 1'b0;
    end else begin
      pl_q <= pl_d; sl_q <= sl_d; tc_q <= tc_d;
      status_q <= status_d; phase_q <= phase_d;
      pcrc_q <= pcrc_d; tcrc_q <= tcrc_d; fcrc_q <= fcrc_d;
      bc_q <= bc_d; mr_q <= mr_d; vv_q <= vv_d; vs_q <= vs_d;
      mode_q <= mode_d; rem_q <= rem_d; op_q <= op_d; dts_q <= dts_d;
      scp_q <= scp_d; tcp_q <= tcp_d; fi_q <= fi_d; tcnt_q <= tcnt_d;
      for (int i = 0; i < 3; i++) chk_q[i] <= chk_d[i];
      rd_ok_q <= rd_ok_d;
      ov_q <= ov_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      icmd_q  <= bps_pkg::cmd_e'(in_cmd_i);
      iaddr_q <= in_addr_i;
      idata_q <= in_data_i;
    end
    if (cmd_i.resp_load) begin
      if (icmd_q == bps_pkg::CMD_READ) begin
        ostat_q <= rd_ok_q ? 4'(status_q) : 4'(bps_pkg::ST_RANGE);
        ord_q   <= rd_ok_q ? tgt_rdata : 8'd0;
      end else begin
        ostat_q <= 4'(status_q);
        ord_q   <= 8'd0;
      end
      ots_q <= dts_q;
    end
  end

  assign status_o.is_patch  = (icmd_q == bps_pkg::CMD_PATCH);
  assign status_o.run_start = run_start;
  assign status_o.fin_start = fin_start;
  assign status_o.run_done  = run_done;
  assign status_o.run_fault = run_fault;
  assign status_o.fin_last  = fin_last;
  assign status_o.out_free  = !ov_q || out_ready_i;

  assign out_valid_o       = ov_q;
  assign out_status_o      = ostat_q;
  assign out_read_data_o   = ord_q;
  assign out_target_size_o = ots_q;

endmodule

// ===== rtl/core/bps_ctrl.sv =====
// sequencing state machine of the bps patch applier
module bps_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  bps_pkg::dp_status_t status_i,
  output bps_pkg::ctrl_cmd_t  cmd_o
);

  bps_pkg::state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bps_pkg::S_IDLE: if (in_valid_i) state_d = bps_pkg::S_EXEC;
      bps_pkg::S_EXEC: begin
        if (status_i.is_patch && status_i.run_start)      state_d = bps_pkg::S_RUN_RD;
        else if (status_i.is_patch && status_i.fin_start) state_d = bps_pkg::S_FIN_RD;
        else                                               state_d = bps_pkg::S_RESP;
      end
      bps_pkg::S_RUN_RD: begin
        if (status_i.run_done || status_i.run_fault) state_d = bps_pkg::S_RESP;
        else                                          state_d = bps_pkg::S_RUN_WR;
      end
      bps_pkg::S_RUN_WR:  state_d = bps_pkg::S_RUN_RD;
      bps_pkg::S_FIN_RD:  state_d = status_i.fin_last ? bps_pkg::S_RESP : bps_pkg::S_FIN_CRC;
      bps_pkg::S_FIN_CRC: state_d = bps_pkg::S_FIN_RD;
      bps_pkg::S_RESP:    if (status_i.out_free) state_d = bps_pkg::S_IDLE;
      default:            state_d = bps_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o      = (state_q == bps_pkg::S_IDLE);
    cmd_o           = '0;
    cmd_o.load_item = in_valid_i && in_ready_o;
    unique case (state_q)
      bps_pkg::S_EXEC:    cmd_o.exec      = 1'b1;
      bps_pkg::S_RUN_RD:  cmd_o.run_check = 1'b1;
      bps_pkg::S_RUN_WR:  cmd_o.run_write = 1'b1;
      bps_pkg::S_FIN_RD:  cmd_o.fin_check = 1'b1;
      bps_pkg::S_FIN_CRC: cmd_o.fin_acc   = 1'b1;
      bps_pkg::S_RESP:    cmd_o.resp_load = status_i.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bps_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_wr_after_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == bps_pkg::S_RUN_WR |-> $past(state_q) == bps_pkg::S_RUN_RD)
    else $error("run write without a preceding read");

  a_crc_after_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == bps_pkg::S_FIN_CRC |-> $past(state_q) == bps_pkg::S_FIN_RD)
    else $error("source crc step without a preceding read");

  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.exec, cmd_o.run_check, cmd_o.run_write,
              cmd_o.fin_check, cmd_o.fin_acc, cmd_o.resp_load}))
    else $error("more than one datapath command");

  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q == bps_pkg::S_EXEC)
    else $error("accepted word not executed");

endmodule

// ===== tb/sv/bps_patch_checker.sv =====
// watches the patch applier streams, predicts every result word and compares
`timescale 1ns / 1ps

package bps_tb_pkg;

  // reflected crc-32 over one byte, init and final invert left to the caller
  function automatic logic [31:0] crc_step(logic [31:0] crc, logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ 32'hEDB88320) : (c >> 1);
    end
    return c;
  endfunction

endpackage

module bps_patch_checker
  import bps_pkg::*;
  import bps_tb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [23:0] cfg_data_i,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  input  logic [23:0] s_axis_tdata_i,
  input  logic [1:0]  s_axis_tuser_i,
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  input  logic [31:0] m_axis_tdata_i,
  output int          pending_o,
  output int          mismatches_o
);

  typedef struct packed {
    logic [3:0]  status;
    logic [7:0]  rd;
    logic [16:0] tsize;
  } reply_t;

  reply_t replies_due[$];

  logic [23:0] patch_len;
  logic [16:0] src_len, tgt_cap;
  logic [7:0]  src_mem [0:65535];
  logic [7:0]  tgt_mem [0:65535];
  logic [31:0] patch_crc, tgt_crc;
  phase_e      phase;
  logic [23:0] consumed;
  logic [63:0] vval;
  int unsigned vshift;
  logic [1:0]  run_kind;
  int unsigned run_left, out_pos, src_pos, tgt_pos, trailer_cnt;
  logic [23:0] markup_left;
  logic [31:0] sums [3];
  logic [16:0] decl_size;
  status_e     job;

  function automatic int unsigned src_eff();
    return (src_len > 17'd65536) ? 65536 : int'(src_len);
  endfunction

  function automatic int unsigned cap_eff();
    return (tgt_cap > 17'd65536) ? 65536 : int'(tgt_cap);
  endfunction

  function automatic void job_clear();
    patch_crc   = '1;
    tgt_crc     = '1;
    phase       = PH_HEADER;
    consumed    = '0;
    vval        = '0;
    vshift      = 0;
    run_kind    = '0;
    run_left    = 0;
    out_pos     = 0;
    src_pos     = 0;
    tgt_pos     = 0;
    markup_left = '0;
    for (int i = 0; i < 3; i++) sums[i] = '0;
    decl_size   = '0;
    trailer_cnt = 0;
    job         = ST_IDLE;
  endfunction

  // bps varints add an implicit 1 << shift at the next shift per continuation byte
  function automatic bit vint_feed(logic [7:0] x);
    if (vshift < 64) vval += {57'd0, x[6:0]} << vshift;
    if (x[7]) return 1'b1;
    vshift = (vshift < 64) ? vshift + 7 : 70;
    if (vshift < 64) vval += 64'd1 << vshift;
    return 1'b0;
  endfunction

  function automatic void put_target(logic [7:0] b);
    tgt_mem[out_pos[15:0]] = b;
    tgt_crc = crc_step(tgt_crc, b);
    out_pos++;
  endfunction

  function automatic void to_cmd();
    vval   = '0;
    vshift = 0;
    phase  = (int'(consumed) + 12 < int'(patch_len)) ? PH_CMD : PH_TRAILER;
  endfunction

  function automatic void close_job();
    logic [31:0] c;
    c = '1;
    for (int unsigned i = 0; i < src_eff(); i++) c = crc_step(c, src_mem[i]);
    phase = PH_DONE;
    if (~c != sums[0]) job = ST_CRC_SRC;
    else if (~tgt_crc != sums[1]) job = ST_CRC_TGT;
    else if (~patch_crc != sums[2]) job = ST_CRC_PATCH;
    else job = ST_OK;
  endfunction

  function automatic void copy_run();
    bit          from_src;
    int unsigned p, lim;
    logic [63:0] mag;
    from_src = (run_kind == 2'd2);
    p   = from_src ? src_pos : tgt_pos;
    mag = vval >> 1;
    if (vval[0]) begin
      if (mag > p) begin
        job = ST_RANGE;
        return;
      end
      p -= mag;
    end else begin
      if (mag >= 65536) begin
        job = ST_RANGE;
        return;
      end
      p += mag;
    end
    while (run_left > 0) begin
      lim = from_src ? src_eff() : out_pos;
      if (p >= lim) begin
        job = ST_RANGE;
        return;
      end
      put_target(from_src ? src_mem[p[15:0]] : tgt_mem[p[15:0]]);
      p++;
      run_left--;
    end
    if (from_src) src_pos = p;
    else tgt_pos = p;
    to_cmd();
  endfunction

  function automatic void take_patch(logic [7:0] b);
    logic [7:0]  want;
    logic [63:0] len;
    if (job == ST_IDLE) begin
      if (patch_len < 24'd19) begin
        job = ST_SMALL;
        return;
      end
      job = ST_RUNNING;
    end
    if (job != ST_RUNNING) return;
    if (consumed < 24'hFFFFFF) consumed++;
    if (!(phase == PH_TRAILER && trailer_cnt >= 8)) patch_crc = crc_step(patch_crc, b);
    case (phase)
      PH_HEADER: begin
        case (2'(consumed - 24'd1))
          2'd0:    want = 8'h42;
          2'd1:    want = 8'h50;
          2'd2:    want = 8'h53;
          default: want = 8'h31;
        endcase
        if (b != want) begin
          job = ST_HEADER;
          return;
        end
        if (consumed >= 24'd4) begin
          phase  = PH_SRC_SIZE;
          vval   = '0;
          vshift = 0;
        end
      end
      PH_SRC_SIZE: begin
        if (vint_feed(b)) begin
          if (vval > src_eff()) begin
            job = ST_SRC_SMALL;
            return;
          end
          phase  = PH_TGT_SIZE;
          vval   = '0;
          vshift = 0;
        end
      end
      PH_TGT_SIZE: begin
        if (vint_feed(b)) begin
          decl_size = (vval > 64'h1FFFF) ? 17'h1FFFF : vval[16:0];
          if (vval > cap_eff()) begin
            job = ST_TGT_SMALL;
            return;
          end
          phase  = PH_MARKUP_SIZE;
          vval   = '0;
          vshift = 0;
        end
      end
      PH_MARKUP_SIZE: begin
        if (vint_feed(b)) begin
          markup_left = (vval > 64'hFFFFFF) ? 24'hFFFFFF : vval[23:0];
          if (markup_left == 0) to_cmd();
          else phase = PH_MARKUP;
        end
      end
      PH_MARKUP: begin
        markup_left--;
        if (markup_left == 0) to_cmd();
      end
      PH_CMD: begin
        if (vint_feed(b)) begin
          len      = (vval >> 2) + 64'd1;
          run_kind = vval[1:0];
          if (len > cap_eff() - out_pos) begin
            job = ST_RANGE;
            return;
          end
          run_left = len;
          vval     = '0;
          vshift   = 0;
          if (run_kind == 2'd0) begin
            while (run_left > 0) begin
              if (out_pos >= src_eff()) begin
                job = ST_RANGE;
                return;
              end
              put_target(src_mem[out_pos[15:0]]);
              run_left--;
            end
            to_cmd();
          end else if (run_kind == 2'd1) begin
            phase = PH_TREAD;
          end else begin
            phase = PH_OFFSET;
          end
        end
      end
      PH_OFFSET: if (vint_feed(b)) copy_run();
      PH_TREAD: begin
        put_target(b);
        run_left--;
        if (run_left == 0) to_cmd();
      end
      PH_TRAILER: begin
        sums[(trailer_cnt >> 2) % 3] |= {24'd0, b} << (8 * (trailer_cnt & 3));
        trailer_cnt++;
        if (trailer_cnt >= 12) close_job();
      end
      default: ;
    endcase
  endfunction

  function automatic reply_t predict(cmd_e c, logic [15:0] addr, logic [7:0] data);
    reply_t r;
    case (c)
      CMD_LOAD:    src_mem[addr] = data;
      CMD_PATCH:   take_patch(data);
      CMD_RESTART: job_clear();
      default: ;
    endcase
    r.status = job;
    r.rd     = '0;
    r.tsize  = decl_size;
    if (c == CMD_READ) begin
      if (addr < out_pos) r.rd = tgt_mem[addr];
      else r.status = ST_RANGE;
    end
    return r;
  endfunction

  task automatic flag(string name, int unsigned want, int unsigned got);
    mismatches_o++;
    $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, want, got);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    reply_t want, got;
    if (!rst_ni) begin
      patch_len = '0;
      src_len   = '0;
      tgt_cap   = '0;
      job_clear();
      replies_due.delete();
      mismatches_o = 0;
      pending_o    = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_PATCH_LEN: patch_len = cfg_data_i;
          CFG_SRC_LEN:   src_len   = cfg_data_i[16:0];
          CFG_TGT_CAP:   tgt_cap   = cfg_data_i[16:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid_i && s_axis_tready_i)
        replies_due.push_back(predict(cmd_e'(s_axis_tuser_i), s_axis_tdata_i[15:0],
                                      s_axis_tdata_i[23:16]));
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got.status = m_axis_tdata_i[3:0];
        got.rd     = m_axis_tdata_i[11:4];
        got.tsize  = m_axis_tdata_i[28:12];
        if (replies_due.size() == 0) begin
          flag("unexpected word", 0, m_axis_tdata_i);
        end else begin
          want = replies_due.pop_front();
          if (got.status != want.status) flag("status", want.status, got.status);
          if (got.rd != want.rd) flag("read_data", want.rd, got.rd);
          if (got.tsize != want.tsize) flag("target_size", want.tsize, got.tsize);
        end
      end
      pending_o = replies_due.size();
    end
  end

endmodule

// ===== tb/sv/tb_top.sv =====
// stimulus and verdict for the bps patch applier core
`timescale 1ns / 1ps

module tb_top;
  import bps_pkg::*;
  import bps_tb_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_idx = CFG_PATCH_LEN;
  logic [23:0] cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic [1:0]  s_tuser = CMD_LOAD;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  int          pending, mismatches;

  int          words_sent = 0;
  bit          calm = 1'b0;
  int          stall_left = 0;
  logic [7:0]  patch_q[$];
  logic [7:0]  src_img[$];

  bps_patch_applier_core uut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_idx),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  bps_patch_checker u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_idx),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_i (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_i (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_i  (m_tdata),
    .pending_o       (pending),
    .mismatches_o    (mismatches)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // result side: mostly ready, short stalls, now and then a long one
  always @(posedge clk) begin
    int r;
    r = $urandom_range(0, 99);
    if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else if (calm || r < 70) begin
      m_tready <= 1'b1;
    end else begin
      stall_left = (r < 95) ? $urandom_range(0, 2) : $urandom_range(5, 30);
      m_tready <= 1'b0;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int lesser(int a, int b);
    return (a < b) ? a : b;
  endfunction

  task automatic send_word(cmd_e c, logic [15:0] a, logic [7:0] d);
    int g;
    g = pick_gap();
    if (g > 0) begin
      s_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= c;
    s_tdata  <= {d, a};
    do @(posedge clk); while (!s_tready);
    words_sent++;
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  task automatic set_regs(logic [23:0] pl, logic [23:0] sl, logic [23:0] tc);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_PATCH_LEN;
    cfg_data <= pl;
    @(posedge clk);
    cfg_idx  <= CFG_SRC_LEN;
    cfg_data <= sl;
    @(posedge clk);
    cfg_idx  <= CFG_TGT_CAP;
    cfg_data <= tc;
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  function automatic void put_varint(longint unsigned v);
    logic [7:0] x;
    forever begin
      x = 8'(v & 64'h7f);
      v = v >> 7;
      if (v == 0) begin
        patch_q.push_back(x | 8'h80);
        break;
      end
      patch_q.push_back(x);
      v--;
    end
  endfunction

  function automatic void put_crc(logic [31:0] c);
    for (int k = 0; k < 4; k++) patch_q.push_back(8'(~c >> (8 * k)));
  endfunction

  // builds a well-formed patch turning src_img into a random target
  function automatic void build_patch(int srcn, int tgtn, int mk);
    logic [7:0]  tgt[$];
    logic [31:0] c;
    int          room, outp, len, p, kind, pos_s, pos_t;
    longint      off;
    pos_s = 0;
    pos_t = 0;
    patch_q = '{8'h42, 8'h50, 8'h53, 8'h31};
    put_varint(srcn);
    put_varint(tgtn);
    put_varint(mk);
    repeat (mk) patch_q.push_back(8'($urandom));
    while (tgt.size() < tgtn) begin
      room = tgtn - tgt.size();
      outp = tgt.size();
      kind = $urandom_range(0, 3);
      if (kind == 0 && outp < srcn) begin
        len = $urandom_range(1, lesser(lesser(room, srcn - outp), 16));
        put_varint(longint'(len - 1) << 2);
        for (int i = 0; i < len; i++) tgt.push_back(src_img[outp + i]);
      end else if (kind == 2 && srcn > 0) begin
        p   = $urandom_range(0, srcn - 1);
        len = $urandom_range(1, lesser(lesser(room, srcn - p), 16));
        put_varint((longint'(len - 1) << 2) | 2);
        off = p - pos_s;
        put_varint(off < 0 ? (((-off) << 1) | 1) : (off << 1));
        for (int i = 0; i < len; i++) tgt.push_back(src_img[p + i]);
        pos_s = p + len;
      end else if (kind == 3 && outp > 0) begin
        p   = $urandom_range(0, outp - 1);
        len = $urandom_range(1, lesser(room, 16));
        put_varint((longint'(len - 1) << 2) | 3);
        off = p - pos_t;
        put_varint(off < 0 ? (((-off) << 1) | 1) : (off << 1));
        // overlapping copies repeat the pattern, like the real format
        for (int i = 0; i < len; i++) tgt.push_back(tgt[p + i]);
        pos_t = p + len;
      end else begin
        len = $urandom_range(1, lesser(room, 16));
        put_varint((longint'(len - 1) << 2) | 1);
        for (int i = 0; i < len; i++) begin
          tgt.push_back(8'($urandom));
          patch_q.push_back(tgt[$]);
        end
      end
    end
    c = '1;
    for (int i = 0; i < srcn; i++) c = crc_step(c, src_img[i]);
    put_crc(c);
    c = '1;
    foreach (tgt[i]) c = crc_step(c, tgt[i]);
    put_crc(c);
    c = '1;
    foreach (patch_q[i]) c = crc_step(c, patch_q[i]);
    put_crc(c);
  endfunction

  initial begin
    logic [7:0] long_hdr[$];
    int srcn, tgtn, mk, pl, sl, tc, fault, feed_n, idx;
    long_hdr = '{8'h42, 8'h50, 8'h53, 8'h31, 8'h80, 8'h7f, 8'h7f, 8'h7f, 8'h7f,
                 8'h7f, 8'h7f, 8'h7f, 8'h7f, 8'h7f, 8'h7f, 8'hff};
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: read before anything is written, store corner
    send_word(CMD_READ, 16'hFFFF, 8'h00);
    send_word(CMD_LOAD, 16'hFFFF, 8'hFF);
    // patch shorter than the minimum, then a byte after the final status
    drain();
    set_regs(24'd0, 24'd0, 24'd0);
    send_word(CMD_PATCH, 16'h0000, 8'h42);
    send_word(CMD_PATCH, 16'h0000, 8'h50);
    send_word(CMD_RESTART, 16'h0000, 8'h00);
    // all registers at their top, broken magic
    drain();
    set_regs(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
    send_word(CMD_PATCH, 16'h0000, 8'h42);
    send_word(CMD_PATCH, 16'h0000, 8'h50);
    send_word(CMD_PATCH, 16'h0000, 8'h58);
    send_word(CMD_RESTART, 16'h0000, 8'h00);
    // target size varint past 64 bits: saturated size and target too small
    foreach (long_hdr[i]) send_word(CMD_PATCH, 16'h0000, long_hdr[i]);

    while (words_sent < 1350) begin
      calm = ($urandom_range(0, 3) == 0);
      srcn = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 300) : $urandom_range(1, 40);
      tgtn = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 300) : $urandom_range(1, 48);
      mk   = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 0;
      src_img.delete();
      repeat (srcn) src_img.push_back(8'($urandom));
      build_patch(srcn, tgtn, mk);
      pl = patch_q.size();
      sl = srcn;
      tc = tgtn + $urandom_range(0, 20);
      feed_n = patch_q.size();
      fault = $urandom_range(0, 9);
      case (fault)
        0: begin
          idx = $urandom_range(0, patch_q.size() - 1);
          patch_q[idx] ^= 8'(1 << $urandom_range(0, 7));
        end
        1: if (srcn > 0) sl = srcn - 1;
        2: if (tgtn > 0) tc = tgtn - 1;
        3: pl = (pl > 3) ? pl + $urandom_range(0, 6) - 3 : pl;
        4: feed_n = $urandom_range(1, patch_q.size() - 1);
        default: ;
      endcase
      drain();
      set_regs(24'(pl), 24'(sl), 24'(tc));
      // stray loads anywhere first, the real image overwrites what matters
      repeat ($urandom_range(0, 2))
        send_word(CMD_LOAD, 16'($urandom_range(0, 65535)), 8'($urandom));
      foreach (src_img[i]) send_word(CMD_LOAD, 16'(i), src_img[i]);
      send_word(CMD_RESTART, 16'($urandom), 8'($urandom));
      for (int i = 0; i < feed_n; i++) begin
        if ($urandom_range(0, 11) == 0)
          send_word(CMD_READ, 16'($urandom_range(0, tgtn + 3)), 8'($urandom));
        send_word(CMD_PATCH, 16'($urandom), patch_q[i]);
      end
      repeat (3) begin
        if ($urandom_range(0, 3) == 0)
          send_word(CMD_READ, 16'($urandom_range(0, 65535)), 8'($urandom));
        else
          send_word(CMD_READ, 16'($urandom_range(0, tgtn + 1)), 8'($urandom));
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  initial begin
    #4000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
